@@ rtl/tlps_pkg.sv @@
// Shared types, codes and constants of the throw-launch phase sequencer.
package tlps_pkg;

  // Field widths
  localparam int unsigned ACCEL_W   = 16;
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned TOL_W     = 15;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Window arithmetic width: accel +/- (1 g + tolerance) never wraps here
  localparam int unsigned WIN_W = 18;
  localparam logic signed [WIN_W-1:0] ONE_G = 18'sd1024;

  // Default counter width
  localparam int unsigned COUNT_WIDTH_DEF = 11;

  // Flight phases
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_INAIR   = 2'd1,
    PH_HAND    = 2'd2,
    PH_LANDING = 2'd3
  } phase_t;

  // Commands issued with each result word
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_TAKEOFF = 2'd1,
    CMD_LAND    = 2'd2,
    CMD_DONE    = 2'd3
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_TOL     = 3'd0,
    CFG_FREEFALL      = 3'd1,
    CFG_HOVER         = 3'd2,
    CFG_HAND_HEIGHT   = 3'd3,
    CFG_LANDED_HEIGHT = 3'd4,
    CFG_LANDED_TICKS  = 3'd5
  } cfg_idx_t;

  // Configuration register set
  typedef struct packed {
    logic [TOL_W-1:0]           accel_tolerance;
    logic [LIMIT_W-1:0]         freefall_ticks;
    logic [LIMIT_W-1:0]         hover_ticks;
    logic signed [HEIGHT_W-1:0] hand_height;
    logic signed [HEIGHT_W-1:0] landed_height;
    logic [LIMIT_W-1:0]         landed_ticks;
  } cfg_t;

  // Phase and fall flag carried between ticks
  typedef struct packed {
    phase_t phase;
    logic   fall_flag;
  } flight_t;

endpackage

@@ rtl/tlps_cfg.sv @@
// Configuration register file of the throw-launch phase sequencer.
module tlps_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tlps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tlps_pkg::cfg_t                      cfg
);
  import tlps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ACCEL_TOL:     cfg_nxt.accel_tolerance = cfg_data[TOL_W-1:0];
        CFG_FREEFALL:      cfg_nxt.freefall_ticks  = cfg_data[LIMIT_W-1:0];
        CFG_HOVER:         cfg_nxt.hover_ticks     = cfg_data[LIMIT_W-1:0];
        CFG_HAND_HEIGHT:   cfg_nxt.hand_height     = $signed(cfg_data[HEIGHT_W-1:0]);
        CFG_LANDED_HEIGHT: cfg_nxt.landed_height   = $signed(cfg_data[HEIGHT_W-1:0]);
        CFG_LANDED_TICKS:  cfg_nxt.landed_ticks    = cfg_data[LIMIT_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold register values, load defaults at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_tolerance <= 15'd102;
      cfg_r.freefall_ticks  <= 10'd5;
      cfg_r.hover_ticks     <= 10'd200;
      cfg_r.hand_height     <= 16'sd400;
      cfg_r.landed_height   <= 16'sd50;
      cfg_r.landed_ticks    <= 10'd100;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/tlps_step.sv @@
// Per-tick phase transition logic: window checks, dwell counters and commands.
module tlps_step #(
  parameter int unsigned COUNT_WIDTH = tlps_pkg::COUNT_WIDTH_DEF
) (
  input  tlps_pkg::cfg_t                        cfg,
  input  tlps_pkg::flight_t                     cur,
  input  logic [COUNT_WIDTH-1:0]                ff_cnt,
  input  logic [COUNT_WIDTH-1:0]                hv_cnt,
  input  logic [COUNT_WIDTH-1:0]                ld_cnt,
  input  logic signed [tlps_pkg::ACCEL_W-1:0]   accel_z,
  input  logic signed [tlps_pkg::HEIGHT_W-1:0]  height,
  output tlps_pkg::flight_t                     nxt,
  output logic [COUNT_WIDTH-1:0]                ff_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]                hv_cnt_nxt,
  output logic [COUNT_WIDTH-1:0]                ld_cnt_nxt,
  output tlps_pkg::cmd_t                        command
);
  import tlps_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic signed [WIN_W-1:0] accel_w;
  logic signed [WIN_W-1:0] tol_w;
  logic                    win_ff;
  logic                    win_hv;
  logic                    below_hand;
  logic                    below_landed;
  logic [COUNT_WIDTH-1:0]  ff_up;
  logic [COUNT_WIDTH-1:0]  hv_up;
  logic [COUNT_WIDTH-1:0]  ld_up;
  logic                    dwell;

  // Widen for window compares so the bounds never wrap
  assign accel_w = {{(WIN_W-ACCEL_W){accel_z[ACCEL_W-1]}}, accel_z};
  assign tol_w   = {{(WIN_W-TOL_W){1'b0}}, cfg.accel_tolerance};

  // Free fall near -1 g, hover near 0 g, both strictly inside the window
  assign win_ff = (accel_w > (-ONE_G - tol_w)) && (accel_w < (-ONE_G + tol_w));
  assign win_hv = (accel_w > -tol_w) && (accel_w < tol_w);

  assign below_hand   = height < cfg.hand_height;
  assign below_landed = height < cfg.landed_height;

  // Saturating increments, cleared when the condition fails
  assign ff_up = !win_ff ? '0 : ((ff_cnt == COUNT_MAX) ? COUNT_MAX : ff_cnt + 1'b1);
  assign hv_up = !win_hv ? '0 : ((hv_cnt == COUNT_MAX) ? COUNT_MAX : hv_cnt + 1'b1);
  assign ld_up = !below_landed ? '0 :
                 ((ld_cnt == COUNT_MAX) ? COUNT_MAX : ld_cnt + 1'b1);

  // Phase decode, then the landed dwell check on hand and landing ticks
  always_comb begin
    nxt        = cur;
    ff_cnt_nxt = ff_cnt;
    hv_cnt_nxt = hv_cnt;
    ld_cnt_nxt = ld_cnt;
    command    = CMD_NONE;
    dwell      = 1'b0;
    unique case (cur.phase)
      PH_IDLE: begin
        ff_cnt_nxt = ff_up;
        if (CMP_W'(ff_up) > CMP_W'(cfg.freefall_ticks)) begin
          ff_cnt_nxt    = '0;
          nxt.fall_flag = 1'b1;
          command       = CMD_TAKEOFF;
          nxt.phase     = PH_INAIR;
        end
      end
      PH_INAIR: begin
        hv_cnt_nxt = hv_up;
        if (CMP_W'(hv_up) > CMP_W'(cfg.hover_ticks)) begin
          hv_cnt_nxt = '0;
          nxt.phase  = PH_HAND;
        end
      end
      PH_HAND: begin
        if (below_hand) begin
          command   = CMD_LAND;
          nxt.phase = PH_LANDING;
        end
        dwell = 1'b1;
      end
      PH_LANDING: begin
        dwell = 1'b1;
      end
      default: begin
        dwell = 1'b0;
      end
    endcase

    if (dwell) begin
      ld_cnt_nxt = ld_up;
      if (CMP_W'(ld_up) > CMP_W'(cfg.landed_ticks)) begin
        ld_cnt_nxt    = '0;
        nxt.fall_flag = 1'b0;
        command       = CMD_DONE;
        nxt.phase     = PH_IDLE;
      end
    end
  end

endmodule

@@ rtl/throw_launch_phase_sequencer_unit.sv @@
// Top level of the throw-launch phase sequencer: input and result registers, flight state.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one estimator word per tick:
//   in_accel_z (1/1024 g) and in_height (mm), both signed 16 bit.
//   Result channel (out_valid/out_ready) gives one word per input word:
//   out_phase after the tick, out_command and out_fall_flag.
//   Configuration port: cfg_wr_en, cfg_index and cfg_data write one register
//   per cycle; write only while no word is in flight.
// Timing:
//   A word is captured in the input register, its phase update is computed
//   combinationally from that register and the flight state, and the result
//   is held in the result register, whose out_valid rises when the word
//   advances. The flight state is updated once per advanced word, so one
//   word is accepted every cycle while the result channel does not stall.
//   When out_ready is low the result register holds, the input register still
//   accepts one more word, and in_ready drops until the result is taken.
//   Reset clears both valid bits, the phase (idle), counters and fall flag and
//   loads the default configuration.
module throw_launch_phase_sequencer_unit #(
  parameter int unsigned COUNT_WIDTH = tlps_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tlps_pkg::ACCEL_W-1:0]  in_accel_z,
  input  logic signed [tlps_pkg::HEIGHT_W-1:0] in_height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_phase,
  output logic [1:0]                           out_command,
  output logic                                 out_fall_flag,
  input  logic                                 cfg_wr_en,
  input  logic [tlps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tlps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tlps_pkg::*;

  cfg_t cfg;

  // Input register
  logic                       in_valid_r;
  logic signed [ACCEL_W-1:0]  accel_r;
  logic signed [HEIGHT_W-1:0] height_r;

  // Flight state
  flight_t                 flight_r;
  flight_t                 flight_nxt;
  logic [COUNT_WIDTH-1:0]  ff_cnt_r;
  logic [COUNT_WIDTH-1:0]  hv_cnt_r;
  logic [COUNT_WIDTH-1:0]  ld_cnt_r;
  logic [COUNT_WIDTH-1:0]  ff_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  hv_cnt_nxt;
  logic [COUNT_WIDTH-1:0]  ld_cnt_nxt;
  cmd_t                    cmd_nxt;

  // Result register
  logic    out_valid_r;
  phase_t  out_phase_r;
  cmd_t    out_command_r;
  logic    out_fall_flag_r;

  logic    advance;
  logic    in_take;

  tlps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlps_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .cur        (flight_r),
    .ff_cnt     (ff_cnt_r),
    .hv_cnt     (hv_cnt_r),
    .ld_cnt     (ld_cnt_r),
    .accel_z    (accel_r),
    .height     (height_r),
    .nxt        (flight_nxt),
    .ff_cnt_nxt (ff_cnt_nxt),
    .hv_cnt_nxt (hv_cnt_nxt),
    .ld_cnt_nxt (ld_cnt_nxt),
    .command    (cmd_nxt)
  );

  // Advance a word when the result register is free or being emptied
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Input payload
  always_ff @(posedge clk) begin
    if (in_take) begin
      accel_r  <= in_accel_z;
      height_r <= in_height;
    end
  end

  // Flight state update, one step per advanced word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r.phase     <= PH_IDLE;
      flight_r.fall_flag <= 1'b0;
      ff_cnt_r           <= '0;
      hv_cnt_r           <= '0;
      ld_cnt_r           <= '0;
    end else if (advance) begin
      flight_r <= flight_nxt;
      ff_cnt_r <= ff_cnt_nxt;
      hv_cnt_r <= hv_cnt_nxt;
      ld_cnt_r <= ld_cnt_nxt;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_phase_r     <= flight_nxt.phase;
      out_command_r   <= cmd_nxt;
      out_fall_flag_r <= flight_nxt.fall_flag;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_phase     = out_phase_r;
  assign out_command   = out_command_r;
  assign out_fall_flag = out_fall_flag_r;

  // The fall flag is set exactly while the craft is out of idle
  a_flag_phase: assert property (@(posedge clk) disable iff (!rst_n)
    flight_r.fall_flag == (flight_r.phase != PH_IDLE))
    else $error("fall flag out of step with phase");

  // Takeoff word reports in-air with the flag set
  a_takeoff: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_command_r == CMD_TAKEOFF) |->
      (out_phase_r == PH_INAIR && out_fall_flag_r))
    else $error("takeoff word with wrong phase or flag");

  // Done word reports idle with the flag cleared
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_command_r == CMD_DONE) |->
      (out_phase_r == PH_IDLE && !out_fall_flag_r))
    else $error("done word with wrong phase or flag");

  // State only moves when a word advances
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flight_r))
    else $error("flight state changed without a word");

endmodule
